// File: sv/mfd_pkg.sv
// Shared types and constants for the motor feedback frame decoder.
`timescale 1ns / 1ps
package mfd_pkg;

  localparam int unsigned IDX_W = 4;
  localparam int unsigned DIR_W = 12;
  localparam int unsigned ADDR_W = 5;

  // Command codes carried above the motor nibble of the identifier.
  localparam logic [6:0] CMD_COMBO_LO = 7'h09;
  localparam logic [6:0] CMD_COMBO_HI = 7'h0B;
  localparam logic [6:0] CMD_POSITION = 7'h0C;
  localparam logic [6:0] CMD_VELOCITY = 7'h0D;
  localparam logic [6:0] CMD_TORQUE = 7'h0E;
  localparam logic [3:0] COMBO_LENGTH = 4'd8;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_POS_RATIO = 3'd0;
  localparam logic [2:0] REG_VEL_RATIO = 3'd1;
  localparam logic [2:0] REG_TOR_RATIO = 3'd2;
  localparam logic [2:0] REG_JUMP_LIMIT = 3'd3;
  localparam logic [2:0] REG_DIR_MASK = 3'd4;

  // Operation kinds handed from the front to the back.
  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_ZERO  = 3'd1,
    K_OTHER = 3'd2,
    K_POS   = 3'd3,
    K_VEL   = 3'd4,
    K_TOR   = 3'd5,
    K_COMBO = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  idx;
    logic              chan;
    logic              f_neg;
    logic [31:0]       f_mag;
    logic              t_neg;
    logic [15:0]       t_mag;
    logic              v_neg;
    logic [15:0]       v_mag;
    logic [31:0]       offset;
  } op_t;

endpackage

// File: sv/motor_feedback_frame_decoder.sv
// Top level of the motor feedback frame decoder with its register port.
`timescale 1ns / 1ps
//
//   Channel   Handshake                   Beat contents
//   input     in_valid_i / in_stall_o     opcode, bus channel, frame, zero offset
//   output    out_valid_o / out_stall_i   motor state after the beat
//   config    APB psel/penable/pwrite     ratios, jump limit, direction mask
//
// A beat enters a two-entry queue the cycle it is accepted and can reach the
// back end on the next cycle. The back end works one beat at a time through a
// single shared 32x32 multiplier: a beat that updates nothing skips it, a
// single-value frame takes a scaling pass, and an eight-byte frame takes two
// multiplier passes per integer field. The result is then registered.
// Reset clears the queue, the sequencer, all motor tables and the registers.
// The input stalls only when the queue is full; the back end stalls only on
// a result still held in the output register.
module motor_feedback_frame_decoder import mfd_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 12,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic                   bus_channel_i,
  input  logic [10:0]            frame_id_i,
  input  logic [3:0]             frame_length_i,
  input  logic [31:0]            bytes_low_i,
  input  logic [31:0]            bytes_high_i,
  input  logic [3:0]             motor_select_i,
  input  logic signed [31:0]     offset_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic [3:0]             motor_index_o,
  output logic                   last_channel_o,
  output logic signed [31:0]     joint_position_o,
  output logic signed [31:0]     joint_velocity_o,
  output logic signed [31:0]     joint_torque_o,
  output logic [COUNT_WIDTH-1:0] receive_count_o,
  output logic                   velocity_held_o
);

  logic [31:0]      pos_gain_q;
  logic [31:0]      vel_gain_q;
  logic [31:0]      tor_gain_q;
  logic [30:0]      jump_limit_q;
  logic [DIR_W-1:0] dir_mask_q;
  logic [2:0]       reg_idx;
  logic             wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_q <= 32'd13176795;
      vel_gain_q <= 32'd13176795;
      tor_gain_q <= 32'd16106127;
      jump_limit_q <= 31'd655360;
      dir_mask_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POS_RATIO:  pos_gain_q <= pwdata;
        REG_VEL_RATIO:  vel_gain_q <= pwdata;
        REG_TOR_RATIO:  tor_gain_q <= pwdata;
        REG_JUMP_LIMIT: jump_limit_q <= pwdata[30:0];
        REG_DIR_MASK:   dir_mask_q <= pwdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_RATIO:  prdata = pos_gain_q;
      REG_VEL_RATIO:  prdata = vel_gain_q;
      REG_TOR_RATIO:  prdata = tor_gain_q;
      REG_JUMP_LIMIT: prdata = {1'b0, jump_limit_q};
      REG_DIR_MASK:   prdata = {{(32 - DIR_W){1'b0}}, dir_mask_q};
      default:        prdata = '0;
    endcase
  end

  op_t  front_op;
  op_t  head_op;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  // A beat is taken whenever the queue has room.
  assign in_stall_o = q_full;
  assign push = in_valid_i && !q_full;

  mfd_front #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_front (
    .opcode_i       (opcode_i),
    .bus_channel_i  (bus_channel_i),
    .frame_id_i     (frame_id_i),
    .frame_length_i (frame_length_i),
    .bytes_low_i    (bytes_low_i),
    .bytes_high_i   (bytes_high_i),
    .motor_select_i (motor_select_i),
    .offset_value_i (offset_value_i),
    .op_o           (front_op)
  );

  mfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .op_o    (head_op)
  );

  mfd_back #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_op_i           (head_op),
    .q_pop_o          (q_pop),
    .pos_gain_i       (pos_gain_q),
    .vel_gain_i       (vel_gain_q),
    .tor_gain_i       (tor_gain_q),
    .jump_limit_i     (jump_limit_q),
    .dir_mask_i       (dir_mask_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .motor_index_o    (motor_index_o),
    .last_channel_o   (last_channel_o),
    .joint_position_o (joint_position_o),
    .joint_velocity_o (joint_velocity_o),
    .joint_torque_o   (joint_torque_o),
    .receive_count_o  (receive_count_o),
    .velocity_held_o  (velocity_held_o)
  );

endmodule

// File: sv/mfd_front.sv
// Front end: classifies a beat and converts its raw fields to magnitudes.
`timescale 1ns / 1ps
module mfd_front import mfd_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 12
) (
  input  logic             opcode_i,
  input  logic             bus_channel_i,
  input  logic [10:0]      frame_id_i,
  input  logic [3:0]       frame_length_i,
  input  logic [31:0]      bytes_low_i,
  input  logic [31:0]      bytes_high_i,
  input  logic [3:0]       motor_select_i,
  input  logic [31:0]      offset_value_i,
  output op_t              op_o
);

  // IEEE single to Q16.16 magnitude, rounded half away from zero.
  function automatic logic [32:0] float_q16(input logic [31:0] bits);
    logic [7:0]  e;
    logic [23:0] m;
    logic [8:0]  s;
    logic [4:0]  sh;
    logic [25:0] rnd;
    logic [31:0] mag;
    logic        neg;
    e = bits[30:23];
    m = {1'b0, bits[22:0]};
    neg = bits[31];
    s = '0;
    sh = '0;
    rnd = '0;
    if (e == 8'hFF) begin
      mag = 32'h8000_0000;
      if (bits[22:0] != '0) begin
        mag = '0;
        neg = 1'b0;
      end
    end else begin
      if (e == 8'd0) e = 8'd1;
      else m[23] = 1'b1;
      s = {1'b0, e} - 9'd134;
      if (!s[8] && s >= 9'd8) begin
        mag = 32'h8000_0000;
      end else if (!s[8]) begin
        mag = {8'd0, m} << s[2:0];
      end else if ((9'd0 - s) >= 9'd26) begin
        mag = '0;
      end else begin
        sh = 5'((9'd0 - s));
        rnd = ({2'b0, m} + (26'd1 << (sh - 5'd1))) >> sh;
        mag = {6'd0, rnd};
      end
    end
    if (!neg && mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
    if (mag == '0) neg = 1'b0;
    return {neg, mag};
  endfunction

  logic [3:0]  nib;
  logic [6:0]  cmd;
  logic        motor_ok;
  logic [31:0] fsrc;
  logic [32:0] fconv;
  logic [15:0] traw;
  logic [15:0] vraw;

  assign nib = frame_id_i[3:0];
  assign cmd = frame_id_i[10:4];
  assign motor_ok = (nib >= 4'd1) && ({28'd0, nib} <= MOTOR_COUNT);
  assign traw = bytes_low_i[15:0];
  assign vraw = bytes_low_i[31:16];

  always_comb begin
    op_o = '0;
    fsrc = bytes_low_i;
    if (cmd >= CMD_COMBO_LO && cmd <= CMD_COMBO_HI) fsrc = bytes_high_i;
    fconv = float_q16(fsrc);
    op_o.chan = bus_channel_i;
    op_o.f_neg = fconv[32];
    op_o.f_mag = fconv[31:0];
    op_o.t_neg = traw[15];
    op_o.t_mag = traw[15] ? 16'(17'h10000 - {1'b0, traw}) : traw;
    op_o.v_neg = vraw[15];
    op_o.v_mag = vraw[15] ? 16'(17'h10000 - {1'b0, vraw}) : vraw;
    op_o.offset = offset_value_i;
    op_o.kind = K_NONE;
    if (opcode_i) begin
      if ({28'd0, motor_select_i} < MOTOR_COUNT) begin
        op_o.kind = K_ZERO;
        op_o.idx = motor_select_i;
      end
    end else if (motor_ok) begin
      op_o.idx = nib - 4'd1;
      priority if (cmd == CMD_POSITION) op_o.kind = K_POS;
      else if (cmd == CMD_VELOCITY) op_o.kind = K_VEL;
      else if (cmd == CMD_TORQUE) op_o.kind = K_TOR;
      else if (cmd >= CMD_COMBO_LO && cmd <= CMD_COMBO_HI &&
               frame_length_i == COMBO_LENGTH) op_o.kind = K_COMBO;
      else op_o.kind = K_OTHER;
    end
  end

endmodule

// File: sv/mfd_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module mfd_queue import mfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output op_t  op_o
);

  op_t        mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q ^ push_i;
    rd_d = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

// File: sv/mfd_back.sv
// Back end: shared multiplier sequencer, per-motor tables and result register.
`timescale 1ns / 1ps
module mfd_back import mfd_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 12,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  op_t                    q_op_i,
  output logic                   q_pop_o,
  input  logic [31:0]            pos_gain_i,
  input  logic [31:0]            vel_gain_i,
  input  logic [31:0]            tor_gain_i,
  input  logic [30:0]            jump_limit_i,
  input  logic [DIR_W-1:0]       dir_mask_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic [3:0]             motor_index_o,
  output logic                   last_channel_o,
  output logic signed [31:0]     joint_position_o,
  output logic signed [31:0]     joint_velocity_o,
  output logic signed [31:0]     joint_torque_o,
  output logic [COUNT_WIDTH-1:0] receive_count_o,
  output logic                   velocity_held_o
);

  localparam int unsigned IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [31:0] RECIP_1000 = 32'd1099511627;
  localparam logic [31:0] RECIP_100 = 32'd2748779069;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DMUL = 7'b0000010,
    S_DFIN = 7'b0000100,
    S_SMUL = 7'b0001000,
    S_SFIN = 7'b0010000,
    S_WR   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    Q_TOR = 2'd0,
    Q_VEL = 2'd1,
    Q_POS = 2'd2
  } qty_e;

  state_e      state_q, state_d;
  qty_e        ph_q, ph_d;
  op_t         op_q;
  logic        flip_q;
  logic [31:0] x_q, x_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [63:0] prod_q;
  logic [31:0] res_q;
  logic        held_q, held_d;

  logic [31:0]            pos_tab_q [MOTOR_COUNT];
  logic [31:0]            vel_tab_q [MOTOR_COUNT];
  logic [31:0]            tor_tab_q [MOTOR_COUNT];
  logic [31:0]            zero_tab_q [MOTOR_COUNT];
  logic [COUNT_WIDTH-1:0] cnt_tab_q [MOTOR_COUNT];
  logic                   chan_tab_q [MOTOR_COUNT];

  logic [IW-1:0] wi;
  logic [15:0]   mask16;
  logic          pop_flip;

  assign wi = op_q.idx[IW-1:0];
  assign mask16 = {{(16 - DIR_W){1'b0}}, dir_mask_i};
  assign pop_flip = mask16[q_op_i.idx];

  // A positive magnitude saturates one below the negative limit.
  function automatic logic [31:0] clamp_mag(input logic neg, input logic [31:0] m);
    return (!neg && m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
  endfunction

  // Multiplier operands.
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = mag_q;
    mul_b = tor_gain_i;
    if (state_q == S_DMUL) begin
      mul_a = x_q;
      mul_b = (ph_q == Q_TOR) ? RECIP_1000 : RECIP_100;
    end else begin
      unique case (ph_q)
        Q_TOR:   mul_b = tor_gain_i;
        Q_VEL:   mul_b = vel_gain_i;
        Q_POS:   mul_b = pos_gain_i;
        default: mul_b = tor_gain_i;
      endcase
    end
  end

  // Quotient correction after the reciprocal multiply.
  logic [25:0] q0;
  logic [33:0] rem;
  logic [33:0] dvs;
  logic [31:0] qfix;
  always_comb begin
    if (ph_q == Q_TOR) begin
      q0 = {2'b0, prod_q[63:40]};
      dvs = 34'd1000;
    end else begin
      q0 = prod_q[63:38];
      dvs = 34'd100;
    end
    rem = {2'b0, x_q} - ({8'd0, q0} * dvs);
    qfix = {6'd0, q0} + ((rem >= dvs) ? 32'd1 : 32'd0);
  end

  // Rounding and saturation of the scaled product.
  logic [63:0] rsum;
  logic [39:0] pr;
  logic [31:0] scaled;
  always_comb begin
    rsum = prod_q + 64'h0000_0000_0080_0000;
    pr = rsum[63:24];
    if (neg_q) begin
      if (pr > 40'h00_8000_0000) pr = 40'h00_8000_0000;
      scaled = 32'(40'd0 - pr);
    end else begin
      if (pr > 40'h00_7FFF_FFFF) pr = 40'h00_7FFF_FFFF;
      scaled = pr[31:0];
    end
  end

  // Offset addition and velocity jump check.
  logic [32:0] psum;
  logic [31:0] pos_new;
  logic [32:0] vdiff;
  logic [32:0] vabs;
  logic        jump_ok;
  always_comb begin
    psum = {res_q[31], res_q} + {zero_tab_q[wi][31], zero_tab_q[wi]};
    pos_new = psum[31:0];
    if (psum[32] != psum[31]) pos_new = psum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    vdiff = {res_q[31], res_q} - {vel_tab_q[wi][31], vel_tab_q[wi]};
    vabs = vdiff[32] ? (33'd0 - vdiff) : vdiff;
    jump_ok = vabs < {2'b0, jump_limit_i};
  end

  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    x_d = x_q;
    mag_d = mag_q;
    neg_d = neg_q;
    held_d = held_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          held_d = 1'b0;
          neg_d = q_op_i.f_neg ^ pop_flip;
          mag_d = clamp_mag(q_op_i.f_neg ^ pop_flip, q_op_i.f_mag);
          x_d = {q_op_i.t_mag, 16'd0} + 32'd500;
          unique case (q_op_i.kind)
            K_POS: begin
              ph_d = Q_POS;
              state_d = S_SMUL;
            end
            K_VEL: begin
              ph_d = Q_VEL;
              state_d = S_SMUL;
            end
            K_TOR: begin
              ph_d = Q_TOR;
              state_d = S_SMUL;
            end
            K_COMBO: begin
              ph_d = Q_TOR;
              state_d = S_DMUL;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_DMUL: state_d = S_DFIN;
      S_DFIN: begin
        mag_d = qfix;
        neg_d = ((ph_q == Q_TOR) ? op_q.t_neg : op_q.v_neg) ^ flip_q;
        state_d = S_SMUL;
      end
      S_SMUL: state_d = S_SFIN;
      S_SFIN: state_d = S_WR;
      S_WR: begin
        state_d = S_OUT;
        if (op_q.kind == K_COMBO) begin
          unique case (ph_q)
            Q_TOR: begin
              ph_d = Q_VEL;
              x_d = {op_q.v_mag, 16'd0} + 32'd50;
              state_d = S_DMUL;
            end
            Q_VEL: begin
              held_d = !jump_ok;
              ph_d = Q_POS;
              neg_d = op_q.f_neg ^ flip_q;
              mag_d = clamp_mag(op_q.f_neg ^ flip_q, op_q.f_mag);
              state_d = S_SMUL;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q <= Q_TOR;
      out_valid_o <= 1'b0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        pos_tab_q[i] <= '0;
        vel_tab_q[i] <= '0;
        tor_tab_q[i] <= '0;
        zero_tab_q[i] <= '0;
        cnt_tab_q[i] <= '0;
        chan_tab_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      if (q_pop_o && q_op_i.kind != K_NONE && q_op_i.kind != K_ZERO) begin
        cnt_tab_q[q_op_i.idx[IW-1:0]] <= cnt_tab_q[q_op_i.idx[IW-1:0]] +
                                         {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        chan_tab_q[q_op_i.idx[IW-1:0]] <= q_op_i.chan;
      end
      if (state_q == S_WR) begin
        unique case (ph_q)
          Q_TOR: tor_tab_q[wi] <= res_q;
          Q_VEL: if (op_q.kind != K_COMBO || jump_ok) vel_tab_q[wi] <= res_q;
          Q_POS: pos_tab_q[wi] <= pos_new;
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free && op_q.kind == K_ZERO) begin
        zero_tab_q[wi] <= op_q.offset;
      end
      if (state_q == S_OUT && out_free) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    held_q <= held_d;
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (state_q == S_SFIN) res_q <= scaled;
    if (q_pop_o) begin
      op_q <= q_op_i;
      flip_q <= pop_flip;
    end
    if (state_q == S_OUT && out_free) begin
      if (op_q.kind == K_NONE) begin
        accepted_o <= 1'b0;
        motor_index_o <= '0;
        last_channel_o <= 1'b0;
        joint_position_o <= '0;
        joint_velocity_o <= '0;
        joint_torque_o <= '0;
        receive_count_o <= '0;
        velocity_held_o <= 1'b0;
      end else begin
        accepted_o <= 1'b1;
        motor_index_o <= op_q.idx;
        last_channel_o <= chan_tab_q[wi];
        joint_position_o <= pos_tab_q[wi];
        joint_velocity_o <= vel_tab_q[wi];
        joint_torque_o <= tor_tab_q[wi];
        receive_count_o <= cnt_tab_q[wi];
        velocity_held_o <= held_q;
      end
    end
  end

endmodule

// File: test/mfd_checker.sv
// Checker for the motor feedback frame decoder: predicts each result and compares it.
`timescale 1ns / 1ps
module mfd_checker import mfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               opcode_i,
  input  logic               bus_channel_i,
  input  logic [10:0]        frame_id_i,
  input  logic [3:0]         frame_length_i,
  input  logic [31:0]        bytes_low_i,
  input  logic [31:0]        bytes_high_i,
  input  logic [3:0]         motor_select_i,
  input  logic [31:0]        offset_value_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic               accepted_o,
  input  logic [3:0]         motor_index_o,
  input  logic               last_channel_o,
  input  logic [31:0]        joint_position_o,
  input  logic [31:0]        joint_velocity_o,
  input  logic [31:0]        joint_torque_o,
  input  logic [15:0]        receive_count_o,
  input  logic               velocity_held_o,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  localparam int MOTORS = 12;
  localparam longint SMAX = 64'h7FFF_FFFF;
  localparam longint SMIN_MAG = 64'h8000_0000;

  typedef struct packed {
    logic        acc;
    logic [3:0]  idx;
    logic        chan;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] tor;
    logic [15:0] cnt;
    logic        held;
  } motor_state_t;

  logic [31:0] pos_gain, vel_gain, tor_gain, jump_limit;
  logic [11:0] dir_mask;
  logic [31:0] pos_tab [MOTORS];
  logic [31:0] vel_tab [MOTORS];
  logic [31:0] tor_tab [MOTORS];
  logic [31:0] zero_tab [MOTORS];
  logic [15:0] cnt_tab [MOTORS];
  logic        chan_tab [MOTORS];
  motor_state_t expected_states [$];

  function automatic longint clamp32(longint v);
    if (v > SMAX) return SMAX;
    if (v < -SMAX - 1) return -SMAX - 1;
    return v;
  endfunction

  // IEEE single to Q16.16 magnitude with round half away and saturation.
  function automatic longint unsigned float_mag(logic [31:0] bits, output bit neg);
    int e;
    longint unsigned m, mag;
    int s;
    e = bits[30:23];
    m = bits[22:0];
    neg = bits[31];
    if (e == 255) begin
      if (m != 0) begin
        neg = 0;
        return 0;
      end
      mag = SMIN_MAG;
    end else begin
      if (e == 0) e = 1;
      else m = m | 64'h80_0000;
      s = e - 134;
      if (s >= 8) mag = SMIN_MAG;
      else if (s >= 0) mag = m << s;
      else if (-s >= 26) mag = 0;
      else mag = (m + (64'd1 << (-s - 1))) >> (-s);
    end
    if (mag > SMIN_MAG) mag = SMIN_MAG;
    if (!neg && mag > SMAX) mag = SMAX;
    if (mag == 0) neg = 0;
    return mag;
  endfunction

  function automatic longint unsigned int16_mag(logic [15:0] raw, int divisor,
                                                output bit neg);
    longint unsigned mag;
    neg = raw[15];
    mag = neg ? (64'h10000 - raw) : raw;
    return (mag * 65536 + divisor / 2) / divisor;
  endfunction

  function automatic longint apply_ratio(bit neg, longint unsigned mag, bit flip,
                                         logic [31:0] ratio);
    longint unsigned p;
    if (flip) neg = !neg;
    if (!neg && mag > SMAX) mag = SMAX;
    p = (mag * ratio + (64'd1 << 23)) >> 24;
    if (neg) begin
      if (p > SMIN_MAG) p = SMIN_MAG;
      return -longint'(p);
    end
    if (p > SMAX) p = SMAX;
    return longint'(p);
  endfunction

  function automatic logic [31:0] joint_pos(logic [31:0] bits, bit flip, int idx);
    bit neg;
    longint unsigned mag;
    mag = float_mag(bits, neg);
    return 32'(clamp32(apply_ratio(neg, mag, flip, pos_gain) +
                       longint'($signed(zero_tab[idx]))));
  endfunction

  // Applies one accepted beat to the predicted motor tables.
  function automatic motor_state_t decode_beat(logic op, logic chan, logic [10:0] fid,
      logic [3:0] len, logic [31:0] lo, logic [31:0] hi, logic [3:0] sel,
      logic [31:0] offs);
    motor_state_t r;
    int idx;
    bit ok, held, flip, neg;
    logic [6:0] cmd;
    longint unsigned mag;
    longint nv, d;
    r = '0;
    ok = 0;
    held = 0;
    idx = 0;
    cmd = fid[10:4];
    if (op) begin
      if (sel < MOTORS) begin
        idx = sel;
        ok = 1;
        zero_tab[idx] = offs;
      end
    end else if (fid[3:0] >= 1 && fid[3:0] <= MOTORS) begin
      idx = fid[3:0] - 1;
      ok = 1;
      flip = dir_mask[idx];
      chan_tab[idx] = chan;
      cnt_tab[idx] = cnt_tab[idx] + 16'd1;
      if (cmd == CMD_POSITION) begin
        pos_tab[idx] = joint_pos(lo, flip, idx);
      end else if (cmd == CMD_VELOCITY) begin
        mag = float_mag(lo, neg);
        vel_tab[idx] = 32'(apply_ratio(neg, mag, flip, vel_gain));
      end else if (cmd == CMD_TORQUE) begin
        mag = float_mag(lo, neg);
        tor_tab[idx] = 32'(apply_ratio(neg, mag, flip, tor_gain));
      end else if (cmd >= CMD_COMBO_LO && cmd <= CMD_COMBO_HI && len == COMBO_LENGTH) begin
        mag = int16_mag(lo[15:0], 1000, neg);
        tor_tab[idx] = 32'(apply_ratio(neg, mag, flip, tor_gain));
        mag = int16_mag(lo[31:16], 100, neg);
        nv = apply_ratio(neg, mag, flip, vel_gain);
        d = nv - longint'($signed(vel_tab[idx]));
        if (d < 0) d = -d;
        if (d < longint'(jump_limit)) vel_tab[idx] = 32'(nv);
        else held = 1;
        pos_tab[idx] = joint_pos(hi, flip, idx);
      end
    end
    if (ok) begin
      r.acc = 1;
      r.idx = idx;
      r.chan = chan_tab[idx];
      r.pos = pos_tab[idx];
      r.vel = vel_tab[idx];
      r.tor = tor_tab[idx];
      r.cnt = cnt_tab[idx];
      r.held = held;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motor_state_t want;
    if (!rst_ni) begin
      pos_gain = 32'd13176795;
      vel_gain = 32'd13176795;
      tor_gain = 32'd16106127;
      jump_limit = 32'd655360;
      dir_mask = '0;
      for (int i = 0; i < MOTORS; i++) begin
        pos_tab[i] = '0; vel_tab[i] = '0; tor_tab[i] = '0;
        zero_tab[i] = '0; cnt_tab[i] = '0; chan_tab[i] = 0;
      end
      expected_states.delete();
      errors = 0;
      pending = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_POS_RATIO: pos_gain = pwdata;
          REG_VEL_RATIO: vel_gain = pwdata;
          REG_TOR_RATIO: tor_gain = pwdata;
          REG_JUMP_LIMIT: jump_limit = {1'b0, pwdata[30:0]};
          REG_DIR_MASK: dir_mask = pwdata[11:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          report("unexpected result beat, accepted", {31'd0, accepted_o}, '0);
        end else begin
          want = expected_states.pop_front();
          if (accepted_o !== want.acc) report("accepted", accepted_o, want.acc);
          if (motor_index_o !== want.idx) report("motor_index", motor_index_o, want.idx);
          if (last_channel_o !== want.chan) report("last_channel", last_channel_o, want.chan);
          if (joint_position_o !== want.pos) report("position", joint_position_o, want.pos);
          if (joint_velocity_o !== want.vel) report("velocity", joint_velocity_o, want.vel);
          if (joint_torque_o !== want.tor) report("torque", joint_torque_o, want.tor);
          if (receive_count_o !== want.cnt) report("count", receive_count_o, want.cnt);
          if (velocity_held_o !== want.held) report("held", velocity_held_o, want.held);
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_states.push_back(decode_beat(opcode_i, bus_channel_i, frame_id_i,
            frame_length_i, bytes_low_i, bytes_high_i, motor_select_i, offset_value_i));
      pending = expected_states.size();
    end
  end
endmodule

// File: test/tb.sv
// Testbench top for the motor feedback frame decoder: stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import mfd_pkg::*;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic              opcode_i = 0, bus_channel_i = 0;
  logic [10:0]       frame_id_i = '0;
  logic [3:0]        frame_length_i = '0;
  logic [31:0]       bytes_low_i = '0, bytes_high_i = '0;
  logic [3:0]        motor_select_i = '0;
  logic signed [31:0] offset_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic              accepted_o, last_channel_o, velocity_held_o;
  logic [3:0]        motor_index_o;
  logic signed [31:0] joint_position_o, joint_velocity_o, joint_torque_o;
  logic [15:0]       receive_count_o;
  int                errors, pending, results_seen;
  int                beats_sent = 0;
  // Set while the result side is to hold off for a long stretch.
  bit                hold_results = 0;

  motor_feedback_frame_decoder uut (.*);
  mfd_checker checker_i (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

  // Random gap length: mostly zero or short, now and then long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Random result stalls outside beats 901 to 1099; a long stall on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        out_stall_i <= 1;
        for (int i = 0; i < 300; i++) @(posedge clk_i);
        out_stall_i <= 0;
        hold_results = 0;
      end else if (beats_sent > 900 && beats_sent < 1100) begin
        out_stall_i <= 0;
      end else begin
        n = gap_cycles();
        out_stall_i <= (n != 0);
        for (int i = 1; i < n; i++) @(posedge clk_i);
      end
    end
  end

  task automatic reg_write(logic [2:0] index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'({index, 2'b00}); pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // One beat offered on the input; held until it is taken.
  task automatic send_beat(logic op, logic chan, logic [10:0] fid, logic [3:0] len,
      logic [31:0] lo, logic [31:0] hi, logic [3:0] sel, logic [31:0] offs, bit gaps);
    int n;
    n = gaps ? gap_cycles() : 0;
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i <= op; bus_channel_i <= chan; frame_id_i <= fid;
    frame_length_i <= len; bytes_low_i <= lo; bytes_high_i <= hi;
    motor_select_i <= sel; offset_value_i <= offs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // Waits for every expected result, then lets the back end settle.
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // A float that lands in or near the Q16.16 range, with the odd special value.
  function automatic logic [31:0] rand_float();
    int r;
    r = $urandom_range(99);
    if (r < 75) return {1'($urandom), 8'($urandom_range(150, 100)), 23'($urandom)};
    if (r < 80) return {1'($urandom), 8'hFF, 23'($urandom_range(1))};
    if (r < 85) return {1'($urandom), 8'h00, 23'($urandom)};
    return $urandom;
  endfunction

  task automatic random_beat(bit gaps);
    int r;
    logic [6:0] cmd;
    logic [3:0] motor;
    logic [31:0] lo;
    r = $urandom_range(99);
    motor = 4'($urandom_range(12, 1));
    if (r < 5) begin
      send_beat(1, $urandom, $urandom, $urandom, $urandom, $urandom,
                4'($urandom_range(15)), $urandom_range(1) ? $urandom
                : 32'($signed($urandom_range(400000)) - 200000), gaps);
    end else if (r < 12) begin
      // Noise: any identifier, including invalid motor nibbles.
      send_beat(0, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, gaps);
    end else begin
      case ($urandom_range(5))
        0: cmd = CMD_POSITION;
        1: cmd = CMD_VELOCITY;
        2: cmd = CMD_TORQUE;
        default: cmd = 7'($urandom_range(CMD_COMBO_HI, CMD_COMBO_LO));
      endcase
      if (cmd <= CMD_COMBO_HI) begin
        // Half small velocity steps, so the jump limit passes as often as not.
        lo = {$urandom_range(1) ? 16'($signed($urandom_range(200)) - 100) : 16'($urandom),
              16'($urandom)};
        send_beat(0, $urandom, {cmd, motor}, $urandom_range(9) ? COMBO_LENGTH
                  : 4'($urandom_range(15)), lo, rand_float(), $urandom, $urandom, gaps);
      end else begin
        send_beat(0, $urandom, {cmd, motor}, $urandom, rand_float(), $urandom,
                  $urandom, $urandom, gaps);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (3) @(posedge clk_i);

    // Directed: extremes, every command, the special float and frame cases.
    send_beat(0, 1, {CMD_POSITION, 4'd1}, 4, 32'h3F80_0000, 0, 0, 0, 0);
    send_beat(0, 0, {CMD_POSITION, 4'd12}, 0, 32'h7F80_0000, 0, 0, 0, 0);
    send_beat(0, 1, {CMD_POSITION, 4'd2}, 4, 32'hFF80_0000, 0, 0, 0, 0);
    send_beat(0, 0, {CMD_VELOCITY, 4'd3}, 4, 32'h7FC0_0001, 0, 0, 0, 0);
    send_beat(0, 0, {CMD_VELOCITY, 4'd4}, 4, 32'h0000_0001, 0, 0, 0, 0);
    send_beat(0, 1, {CMD_TORQUE, 4'd5}, 4, 32'h4F00_0000, 0, 0, 0, 0);
    send_beat(0, 1, {CMD_TORQUE, 4'd6}, 4, 32'hCF00_0000, 0, 0, 0, 0);
    send_beat(0, 0, {CMD_COMBO_LO, 4'd7}, 8, 32'h0064_03E8, 32'h4000_0000, 0, 0, 0);
    send_beat(0, 1, {CMD_COMBO_HI, 4'd7}, 8, 32'h8000_8000, 32'hC000_0000, 0, 0, 0);
    send_beat(0, 0, {7'h0A, 4'd8}, 8, 32'h7FFF_7FFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_beat(0, 1, {7'h0A, 4'd8}, 7, 32'h0001_0001, 0, 0, 0, 0);
    send_beat(0, 0, {7'h7F, 4'd9}, 15, '1, '1, 15, '1, 0);
    send_beat(0, 1, {7'h0C, 4'd0}, 4, 32'h3F80_0000, 0, 0, 0, 0);
    send_beat(0, 1, {7'h0C, 4'd13}, 4, 32'h3F80_0000, 0, 0, 0, 0);
    send_beat(0, 1, {7'h0C, 4'd15}, 4, 32'h3F80_0000, 0, 0, 0, 0);
    send_beat(1, 1, '1, 15, '1, '1, 4'd0, 32'h7FFF_FFFF, 0);
    send_beat(1, 0, 0, 0, 0, 0, 4'd11, 32'h8000_0000, 0);
    send_beat(1, 0, 0, 0, 0, 0, 4'd12, 32'h1234_5678, 0);
    send_beat(1, 0, 0, 0, 0, 0, 4'd15, 32'h1234_5678, 0);
    send_beat(0, 0, {CMD_POSITION, 4'd1}, 4, 32'h4F00_0000, 0, 0, 0, 0);
    send_beat(0, 0, {CMD_POSITION, 4'd12}, 4, 32'hCF00_0000, 0, 0, 0, 0);
    drain();

    // Random phases, each with its own register setting, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          reg_write(REG_POS_RATIO, '1); reg_write(REG_VEL_RATIO, '1);
          reg_write(REG_TOR_RATIO, '1); reg_write(REG_JUMP_LIMIT, 32'h7FFF_FFFF);
          reg_write(REG_DIR_MASK, 32'hFFF);
        end
        2: begin
          reg_write(REG_POS_RATIO, 0); reg_write(REG_VEL_RATIO, 0);
          reg_write(REG_TOR_RATIO, 0); reg_write(REG_JUMP_LIMIT, 0);
          reg_write(REG_DIR_MASK, 0);
        end
        default: begin
          reg_write(REG_POS_RATIO, $urandom_range(1) ? 32'h0100_0000 : $urandom);
          reg_write(REG_VEL_RATIO, $urandom_range(1) ? 32'h0100_0000 : $urandom);
          reg_write(REG_TOR_RATIO, $urandom);
          reg_write(REG_JUMP_LIMIT, $urandom_range(1) ? $urandom_range(2000000) : $urandom);
          reg_write(REG_DIR_MASK, $urandom);
        end
      endcase
      for (int i = 0; i < 305; i++) begin
        if (phase == 3 && i == 50) hold_results = 1;
        random_beat(!(phase == 3 && i < 100));
      end
      // The sender pauses here until every result is in.
      drain();
    end

    in_valid_i <= 0;
    repeat (50) @(posedge clk_i);
    $display("Run covered %0d input beats and %0d result beats over six register settings",
             beats_sent, results_seen);
    $display("including saturation, NaN, denormal, short frame, jump hold and zero writes.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/mfd_pkg.sv
sv/mfd_front.sv
sv/mfd_queue.sv
sv/mfd_back.sv
sv/motor_feedback_frame_decoder.sv
test/mfd_checker.sv
test/tb.sv
